>>> rtl/core/sal_pkg.sv
// Package for the shifting array list core: sizes, opcodes, status codes
// and the command struct that the controller broadcasts to the cell chain.
// No dependencies.
`default_nettype none

package sal_pkg;

    localparam int CAPACITY = 16;

    localparam int OP_W    = 3;
    localparam int POS_W   = 4;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Internal count holds 0..CAPACITY; cell index holds 0..CAPACITY-1.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Width used when positions, counts and indexes are compared.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_GET    = 3'd3;
    localparam logic [OP_W-1:0] OP_SET    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    typedef struct packed {
        logic              write;      // load wdata at wpos
        logic              shift_up;   // cells above wpos take their lower neighbor
        logic              shift_down; // cells from wpos take their upper neighbor
        logic [CMP_W-1:0]  wpos;
        logic [CMP_W-1:0]  count;      // count before this beat
        logic [DATA_W-1:0] wdata;
    } sal_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/sal_cell.sv
// One storage cell of the list: holds one word and, on each command, keeps
// it, loads the new word, or takes the word of a neighbor. Uses sal_pkg.
`default_nettype none

module sal_cell
    import sal_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [IDX_W-1:0]  idx,
    input  wire sal_cmd_t          cmd,
    input  wire logic [DATA_W-1:0] lower_d,
    input  wire logic [DATA_W-1:0] upper_d,
    output logic      [DATA_W-1:0] q
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [CMP_W-1:0]  my_idx;
    logic [CMP_W-1:0]  top_idx;

    assign my_idx  = CMP_W'(idx);
    assign top_idx = cmd.count - CMP_W'(1);

    always_comb begin
        data_next = data_reg;
        if (cmd.shift_up && (my_idx > cmd.wpos) && (my_idx <= cmd.count)) begin
            data_next = lower_d;
        end
        if (cmd.shift_down && (my_idx >= cmd.wpos)) begin
            // The cell vacated at the top of the list is cleared.
            if (my_idx < top_idx) begin
                data_next = upper_d;
            end else if (my_idx == top_idx) begin
                data_next = '0;
            end
        end
        if (cmd.write && (my_idx == cmd.wpos)) begin
            data_next = cmd.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

>>> rtl/core/sal_ctrl.sv
// Opcode decode for the list: checks range, full and empty, works out the
// new count and builds the command for the cell chain. Uses sal_pkg.
`default_nettype none

module sal_ctrl
    import sal_pkg::*;
(
    input  wire logic              go,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [DATA_W-1:0] item_value,
    input  wire logic [CNT_W-1:0]  count_cur,
    output sal_cmd_t               cmd,
    output logic      [STAT_W-1:0] status,
    output logic                   read_en,
    output logic      [CNT_W-1:0]  count_new
);

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic             do_write;
    logic             do_up;
    logic             do_down;
    logic [CMP_W-1:0] wpos;

    assign pos_c = CMP_W'(position);
    assign cnt_c = CMP_W'(count_cur);

    always_comb begin
        status    = ST_OK;
        read_en   = 1'b0;
        do_write  = 1'b0;
        do_up     = 1'b0;
        do_down   = 1'b0;
        wpos      = pos_c;
        count_new = count_cur;
        case (opcode)
            OP_APPEND: begin
                wpos = cnt_c;
                if (cnt_c >= CAP_CMP) begin
                    status = ST_FULL;
                end else begin
                    do_write  = 1'b1;
                    count_new = count_cur + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (pos_c > cnt_c) begin
                    status = ST_RANGE;
                end else if (cnt_c >= CAP_CMP) begin
                    status = ST_FULL;
                end else begin
                    do_write  = 1'b1;
                    do_up     = 1'b1;
                    count_new = count_cur + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (cnt_c == '0) begin
                    status = ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    status = ST_RANGE;
                end else begin
                    read_en   = 1'b1;
                    do_down   = 1'b1;
                    count_new = count_cur - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (cnt_c == '0) begin
                    status = ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    status = ST_RANGE;
                end else begin
                    read_en = 1'b1;
                end
            end
            OP_SET: begin
                if (pos_c >= CAP_CMP) begin
                    status = ST_RANGE;
                end else begin
                    do_write = 1'b1;
                    // Setting past the end stretches the list to cover it.
                    if (pos_c >= cnt_c) begin
                        count_new = CNT_W'(pos_c + CMP_W'(1));
                    end
                end
            end
            default: begin
                status = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        cmd.write      = go && do_write;
        cmd.shift_up   = go && do_up;
        cmd.shift_down = go && do_down;
        cmd.wpos       = wpos;
        cmd.count      = cnt_c;
        cmd.wdata      = item_value;
    end

endmodule

`default_nettype wire

>>> rtl/core/shifting_array_list_core.sv
// Ordered list of up to CAPACITY signed words kept in a chain of cells that
// shift with their neighbors on insert and remove. One beat is accepted per
// clock while s_ready is high; its result is registered and shows on the
// m_ channel in the next cycle. s_ready drops only while a result waits on
// m_ready, so the output register alone sets the rate. Uses sal_pkg.
`default_nettype none

module shifting_array_list_core
    import sal_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [OP_W-1:0]          s_opcode,
    input  wire logic [POS_W-1:0]         s_position,
    input  wire logic signed [DATA_W-1:0] s_item_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_read_value,
    output logic [STAT_W-1:0]             m_status,
    output logic [COUNT_W-1:0]            m_count
);

    logic                    accept;
    sal_cmd_t                cmd;
    logic [STAT_W-1:0]       status;
    logic                    read_en;
    logic [CNT_W-1:0]        count_new;
    logic [CNT_W-1:0]        count_reg;
    logic                    m_valid_reg;
    logic [DATA_W-1:0]       rdata_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [DATA_W-1:0]       cell_q [CAPACITY];
    logic [DATA_W-1:0]       rd_mux;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    sal_ctrl u_ctrl (
        .go         (accept),
        .opcode     (s_opcode),
        .position   (s_position),
        .item_value (s_item_value),
        .count_cur  (count_reg),
        .cmd        (cmd),
        .status     (status),
        .read_en    (read_en),
        .count_new  (count_new)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] lower_d;
        logic [DATA_W-1:0] upper_d;
        if (i == 0) begin : g_first
            assign lower_d = '0;
        end else begin : g_lower
            assign lower_d = cell_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign upper_d = '0;
        end else begin : g_upper
            assign upper_d = cell_q[i+1];
        end
        sal_cell u_cell (
            .aclk    (aclk),
            .idx     (IDX_W'(i)),
            .cmd     (cmd),
            .lower_d (lower_d),
            .upper_d (upper_d),
            .q       (cell_q[i])
        );
    end

    // Read port: select the cell at the requested position.
    always_comb begin
        rd_mux = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CMP_W'(s_position) == CMP_W'(k)) begin
                rd_mux = cell_q[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_new;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg  <= read_en ? rd_mux : '0;
            status_reg <= status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = rdata_reg;
    assign m_status     = status_reg;
    assign m_count      = COUNT_W'(count_reg);

endmodule

`default_nettype wire

>>> rtl/core/sal_checker.sv
// Port-level checks for shifting_array_list_core, bound to the top level.
// Uses sal_pkg for the capacity and status codes.
`default_nettype none

module sal_checker
    import sal_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic signed [DATA_W-1:0] m_read_value,
    input wire logic [STAT_W-1:0]        m_status,
    input wire logic [COUNT_W-1:0]       m_count
);

    // Every accepted beat produces its result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("no result after an accepted beat");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_count) <= CAPACITY))
        else $error("count above capacity");

    a_fail_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_read_value == '0))
        else $error("read data on a failed beat");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> (32'(m_count) == CAPACITY))
        else $error("full status with room left");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_value)
                                   && $stable(m_status) && $stable(m_count)))
        else $error("stalled result changed");

endmodule

bind shifting_array_list_core sal_checker u_sal_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value),
    .m_status     (m_status),
    .m_count      (m_count)
);

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for shifting_array_list_core: a typed table of list
// operations, then random operation sequences under varied backpressure.
// Depends on sal_pkg and the core RTL only.
module testbench;
    import sal_pkg::*;

    localparam logic [OP_W-1:0] OP_FIRST_BAD = OP_SET + 3'd1;
    localparam logic [OP_W-1:0] OP_LAST_BAD  = 3'd7;
    localparam int POS_MAX    = (1 << POS_W) - 1;
    localparam int NUM_ROWS   = 24;
    localparam int NUM_CHUNKS = 8;
    localparam int CHUNK_LEN  = 106;

    typedef struct packed {
        logic signed [DATA_W-1:0] rd;
        logic [STAT_W-1:0]        st;
        logic [COUNT_W-1:0]       cnt;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic                     known_answer;
        list_result_t             answer;
    } list_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_opcode = OP_APPEND;
    logic [POS_W-1:0]          s_position = '0;
    logic signed [DATA_W-1:0]  s_item_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [DATA_W-1:0]  m_read_value;
    logic [STAT_W-1:0]         m_status;
    logic [COUNT_W-1:0]        m_count;

    // Predicted contents of the list, and which cells hold a defined word.
    logic signed [DATA_W-1:0]  list_words [CAPACITY];
    bit                        word_known [CAPACITY];
    int                        entries_held;

    list_result_t              pending_results [$];
    int                        error_count = 0;
    int                        tx_idle_pct = 0;
    int                        rx_stall_pct = 0;
    int                        hold_left = 0;
    int                        grow_pct = 45;

    list_row_t directed_rows [NUM_ROWS] = '{
        '{OP_GET,       4'd0,  32'sh0,         1'b1, '{32'sh0, ST_EMPTY, 5'd0}},
        '{OP_REMOVE,    4'd0,  32'sh0,         1'b1, '{32'sh0, ST_EMPTY, 5'd0}},
        '{OP_INSERT,    4'd1,  32'sh5,         1'b1, '{32'sh0, ST_RANGE, 5'd0}},
        '{OP_FIRST_BAD, 4'd3,  32'sh0,         1'b1, '{32'sh0, ST_RANGE, 5'd0}},
        '{OP_LAST_BAD,  4'd15, 32'shFFFFFFFF,  1'b1, '{32'sh0, ST_RANGE, 5'd0}},
        '{OP_APPEND,    4'd0,  32'sh7FFFFFFF,  1'b1, '{32'sh0, ST_OK, 5'd1}},
        '{OP_REMOVE,    4'd1,  32'sh0,         1'b1, '{32'sh0, ST_RANGE, 5'd1}},
        '{OP_REMOVE,    4'd0,  32'sh0,         1'b1, '{32'sh7FFFFFFF, ST_OK, 5'd0}},
        '{OP_APPEND,    4'd9,  32'sh80000000,  1'b1, '{32'sh0, ST_OK, 5'd1}},
        '{OP_APPEND,    4'd0,  32'sh7FFFFFFF,  1'b1, '{32'sh0, ST_OK, 5'd2}},
        '{OP_INSERT,    4'd0,  32'shFFFFFFFF,  1'b1, '{32'sh0, ST_OK, 5'd3}},
        '{OP_INSERT,    4'd3,  32'sh5A5AA5A5,  1'b1, '{32'sh0, ST_OK, 5'd4}},
        '{OP_GET,       4'd4,  32'sh0,         1'b1, '{32'sh0, ST_RANGE, 5'd4}},
        '{OP_GET,       4'd1,  32'sh0,         1'b0, '{32'sh0, ST_OK, 5'd0}},
        '{OP_REMOVE,    4'd0,  32'sh0,         1'b0, '{32'sh0, ST_OK, 5'd0}},
        '{OP_REMOVE,    4'd2,  32'sh0,         1'b0, '{32'sh0, ST_OK, 5'd0}},
        '{OP_SET,       4'd15, 32'shAAAA5555,  1'b1, '{32'sh0, ST_OK, 5'd16}},
        '{OP_APPEND,    4'd0,  32'sh1,         1'b1, '{32'sh0, ST_FULL, 5'd16}},
        '{OP_INSERT,    4'd15, 32'sh1,         1'b1, '{32'sh0, ST_FULL, 5'd16}},
        '{OP_GET,       4'd15, 32'sh0,         1'b1, '{32'shAAAA5555, ST_OK, 5'd16}},
        '{OP_REMOVE,    4'd15, 32'sh0,         1'b1, '{32'shAAAA5555, ST_OK, 5'd15}},
        '{OP_SET,       4'd2,  32'sh1,         1'b0, '{32'sh0, ST_OK, 5'd0}},
        '{OP_GET,       4'd2,  32'sh0,         1'b0, '{32'sh0, ST_OK, 5'd0}},
        '{OP_INSERT,    4'd0,  32'sh0,         1'b0, '{32'sh0, ST_OK, 5'd0}}
    };

    shifting_array_list_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_position   (s_position),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_count      (m_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Applies one list operation to the predicted list and returns its result.
    function automatic void apply_list_op(input logic [OP_W-1:0] op,
                                          input logic [POS_W-1:0] pos,
                                          input logic signed [DATA_W-1:0] val,
                                          output list_result_t res);
        int p;
        int i;
        p = pos;
        res.rd = '0;
        res.st = ST_OK;
        case (op)
            OP_APPEND: begin
                if (entries_held >= CAPACITY) begin
                    res.st = ST_FULL;
                end else begin
                    list_words[entries_held] = val;
                    word_known[entries_held] = 1'b1;
                    entries_held++;
                end
            end
            OP_INSERT: begin
                if (p > entries_held) begin
                    res.st = ST_RANGE;
                end else if (entries_held >= CAPACITY) begin
                    res.st = ST_FULL;
                end else begin
                    for (i = entries_held; i > p; i--) begin
                        list_words[i] = list_words[i-1];
                        word_known[i] = word_known[i-1];
                    end
                    list_words[p] = val;
                    word_known[p] = 1'b1;
                    entries_held++;
                end
            end
            OP_REMOVE: begin
                if (entries_held == 0) begin
                    res.st = ST_EMPTY;
                end else if (p >= entries_held) begin
                    res.st = ST_RANGE;
                end else begin
                    res.rd = list_words[p];
                    for (i = p; i + 1 < entries_held; i++) begin
                        list_words[i] = list_words[i+1];
                        word_known[i] = word_known[i+1];
                    end
                    // The vacated top cell is cleared, so it holds a defined zero.
                    list_words[entries_held-1] = '0;
                    word_known[entries_held-1] = 1'b1;
                    entries_held--;
                end
            end
            OP_GET: begin
                if (entries_held == 0) begin
                    res.st = ST_EMPTY;
                end else if (p >= entries_held) begin
                    res.st = ST_RANGE;
                end else begin
                    res.rd = list_words[p];
                end
            end
            OP_SET: begin
                if (p >= CAPACITY) begin
                    res.st = ST_RANGE;
                end else begin
                    list_words[p] = val;
                    word_known[p] = 1'b1;
                    if (p >= entries_held) entries_held = p + 1;
                end
            end
            default: begin
                res.st = ST_RANGE;
            end
        endcase
        res.cnt = COUNT_W'(entries_held);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(19))
            0: return 32'sh0;
            1: return 32'shFFFFFFFF;
            2: return 32'sh7FFFFFFF;
            3: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(input int upper);
        int lim;
        lim = (upper > POS_MAX) ? POS_MAX : upper;
        if (lim < 0 || $urandom_range(99) < 15) return POS_W'($urandom_range(POS_MAX));
        return POS_W'($urandom_range(lim));
    endfunction

    // Mostly legal operations on the current list, with a tunable growth bias.
    task automatic pick_list_op(output logic [OP_W-1:0] op, output logic [POS_W-1:0] pos,
                                output logic signed [DATA_W-1:0] val);
        int r;
        int rest;
        r = $urandom_range(99);
        rest = $urandom_range(99);
        val = pick_word();
        if (r < 3) begin
            op = OP_W'($urandom_range(OP_LAST_BAD, OP_FIRST_BAD));
            pos = POS_W'($urandom_range(POS_MAX));
        end else if (r < 3 + grow_pct) begin
            op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
            pos = pick_pos(entries_held);
        end else if (rest < 50) begin
            op = OP_REMOVE;
            pos = pick_pos(entries_held - 1);
        end else if (rest < 80) begin
            op = OP_GET;
            pos = pick_pos(entries_held - 1);
        end else begin
            op = OP_SET;
            pos = pick_pos($urandom_range(99) < 70 ? entries_held : POS_MAX);
        end
        // A read of a cell that was never written is not allowed; write it instead.
        if ((op == OP_GET || op == OP_REMOVE) && pos < entries_held && !word_known[pos])
            op = OP_SET;
    endtask

    task automatic send_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val,
                                input logic known_answer, input list_result_t answer);
        list_result_t predicted;
        while ($urandom_range(99) < tx_idle_pct) @(negedge aclk) s_valid = 1'b0;
        @(negedge aclk);
        s_valid = 1'b1;
        s_opcode = op;
        s_position = pos;
        s_item_value = val;
        do @(posedge aclk); while (!s_ready);
        apply_list_op(op, pos, val, predicted);
        pending_results.push_back(known_answer ? answer : predicted);
    endtask

    task automatic wait_drained();
        @(negedge aclk) s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Result checker: every beat on the m_ side is matched to the oldest prediction.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result beat with nothing expected: value %0d status %0d count %0d",
                         $time, m_read_value, m_status, m_count);
            end else begin
                want = pending_results.pop_front();
                if (m_read_value !== want.rd) begin
                    error_count++;
                    $display("%0t: read_value expected %0d got %0d", $time, want.rd, m_read_value);
                end
                if (m_status !== want.st) begin
                    error_count++;
                    $display("%0t: status expected %0d got %0d", $time, want.st, m_status);
                end
                if (m_count !== want.cnt) begin
                    error_count++;
                    $display("%0t: count expected %0d got %0d", $time, want.cnt, m_count);
                end
            end
        end
    end

    // Receiver: random stalls, or a long counted hold-off when requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int                       chunk;
        int                       k;

        for (k = 0; k < CAPACITY; k++) begin
            list_words[k] = '0;
            word_known[k] = 1'b0;
        end
        entries_held = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        for (k = 0; k < NUM_ROWS; k++)
            send_list_op(directed_rows[k].op, directed_rows[k].pos, directed_rows[k].val,
                         directed_rows[k].known_answer, directed_rows[k].answer);
        wait_drained();

        for (chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
            case (chunk % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            grow_pct = (chunk % 3 == 0) ? 45 : ((chunk % 3 == 1) ? 65 : 25);
            // The first chunk opens with a long receiver hold-off so the input backs up.
            if (chunk == 0) hold_left = 80;
            for (k = 0; k < CHUNK_LEN; k++) begin
                pick_list_op(op, pos, val);
                send_list_op(op, pos, val, 1'b0, '0);
            end
            wait_drained();
        end

        rx_stall_pct = 0;
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/sal_pkg.sv
rtl/core/sal_cell.sv
rtl/core/sal_ctrl.sv
rtl/core/shifting_array_list_core.sv
rtl/core/sal_checker.sv
test/testbench.sv
